### design/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg: actuator response chain shared definitions
// Sample formats, datapath widths, CSR map, micro-op codes and the
// sequencer control store.
// ----------------------------------------------------------------------------
package arc_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int FRACTION_BITS   = 12;
   localparam int STEP_WIDTH      = 16;
   localparam int TAU_WIDTH       = 24;
   localparam int BLEND_WIDTH     = 17;
   localparam int BLEND_SHIFT     = 16;
   localparam int DEAD_WIDTH      = FRACTION_BITS;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int ONE_Q       = 1 << FRACTION_BITS;
   localparam int BLEND_HALF  = 1 << (BLEND_SHIFT - 1);
   localparam int HALF_RANGE  = 1 << (SAMPLE_WIDTH - 1);

   localparam int MAG_WIDTH   = SAMPLE_WIDTH;
   localparam int MUL_A_WIDTH = (BLEND_WIDTH > STEP_WIDTH) ? BLEND_WIDTH : STEP_WIDTH;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MAG_WIDTH;
   localparam int NUM_WIDTH   = PROD_WIDTH + 1;
   localparam int DEN_WIDTH   = TAU_WIDTH + 1;
   localparam int QUO_WIDTH   = SAMPLE_WIDTH;
   localparam int REM_WIDTH   = DEN_WIDTH + 1;

   localparam logic [BLEND_WIDTH-1:0] BLEND_ONE = BLEND_WIDTH'(1 << BLEND_SHIFT);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = SAMPLE_WIDTH'(HALF_RANGE - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = SAMPLE_WIDTH'(HALF_RANGE);

   localparam logic signed [SAMPLE_WIDTH-1:0] LOWER_RESET = -SAMPLE_WIDTH'(ONE_Q);
   localparam logic signed [SAMPLE_WIDTH-1:0] UPPER_RESET = SAMPLE_WIDTH'(ONE_Q);
   localparam logic signed [SAMPLE_WIDTH-1:0] GAIN_RESET  = SAMPLE_WIDTH'(ONE_Q);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LAG_TIME_CONSTANT,
      CSR_LOWER_LIMIT,
      CSR_UPPER_LIMIT,
      CSR_BLEND_FACTOR,
      CSR_DEAD_BAND,
      CSR_OUTPUT_GAIN
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_JHOLD,
      OP_JBYP,
      OP_LAGMUL,
      OP_DIVGO,
      OP_DIVWAIT,
      OP_LAGFIN,
      OP_BYP,
      OP_CLAMP,
      OP_BLMUL,
      OP_BLFIN,
      OP_DZ,
      OP_DZFIN,
      OP_GMUL,
      OP_GFIN,
      OP_EMIT
   } uop_type;

   localparam int PC_WIDTH = 5;

   typedef struct packed {
      uop_type             op;
      logic                held;
      logic [PC_WIDTH-1:0] target;
   } uword_type;

   typedef struct packed {
      logic busy;
      logic overflow;
   } div_status_type;

   localparam logic [PC_WIDTH-1:0] PC_FETCH  = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] PC_BYPASS = PC_WIDTH'(7);
   localparam logic [PC_WIDTH-1:0] PC_CLAMP  = PC_WIDTH'(8);
   localparam logic [PC_WIDTH-1:0] PC_GAIN   = PC_WIDTH'(15);
   localparam logic [PC_WIDTH-1:0] PC_HOLD   = PC_WIDTH'(18);

   // control store
   function automatic uword_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      uword_type w;
      w = '{op: OP_WAIT, held: 1'b0, target: PC_FETCH};
      unique case (pc)
         5'd0:  w = '{op: OP_WAIT,    held: 1'b0, target: PC_FETCH};
         5'd1:  w = '{op: OP_JHOLD,   held: 1'b0, target: PC_HOLD};
         5'd2:  w = '{op: OP_JBYP,    held: 1'b0, target: PC_BYPASS};
         5'd3:  w = '{op: OP_LAGMUL,  held: 1'b0, target: PC_FETCH};
         5'd4:  w = '{op: OP_DIVGO,   held: 1'b0, target: PC_FETCH};
         5'd5:  w = '{op: OP_DIVWAIT, held: 1'b0, target: PC_FETCH};
         5'd6:  w = '{op: OP_LAGFIN,  held: 1'b0, target: PC_CLAMP};
         5'd7:  w = '{op: OP_BYP,     held: 1'b0, target: PC_FETCH};
         5'd8:  w = '{op: OP_CLAMP,   held: 1'b0, target: PC_FETCH};
         5'd9:  w = '{op: OP_BLMUL,   held: 1'b0, target: PC_FETCH};
         5'd10: w = '{op: OP_BLFIN,   held: 1'b0, target: PC_FETCH};
         5'd11: w = '{op: OP_DZ,      held: 1'b0, target: PC_GAIN};
         5'd12: w = '{op: OP_DIVGO,   held: 1'b0, target: PC_FETCH};
         5'd13: w = '{op: OP_DIVWAIT, held: 1'b0, target: PC_FETCH};
         5'd14: w = '{op: OP_DZFIN,   held: 1'b0, target: PC_FETCH};
         5'd15: w = '{op: OP_GMUL,    held: 1'b0, target: PC_FETCH};
         5'd16: w = '{op: OP_GFIN,    held: 1'b0, target: PC_FETCH};
         5'd17: w = '{op: OP_EMIT,    held: 1'b0, target: PC_FETCH};
         5'd18: w = '{op: OP_EMIT,    held: 1'b1, target: PC_FETCH};
         default: w = '{op: OP_WAIT,  held: 1'b0, target: PC_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic [MAG_WIDTH-1:0] mag_of_diff(
      input logic signed [SAMPLE_WIDTH:0] v);
      logic [SAMPLE_WIDTH:0] n;
      n = v[SAMPLE_WIDTH] ? -v : v;
      return n[MAG_WIDTH-1:0];
   endfunction

   function automatic logic [MAG_WIDTH-1:0] mag_of_sample(
      input logic signed [SAMPLE_WIDTH-1:0] v);
      logic [SAMPLE_WIDTH-1:0] n;
      n = v[SAMPLE_WIDTH-1] ? -v : v;
      return n;
   endfunction

   // base +/- mag, result known to stay in sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] add_signed_mag(
      input logic signed [SAMPLE_WIDTH-1:0] base,
      input logic                           neg,
      input logic [MAG_WIDTH-1:0]           mag);
      logic signed [SAMPLE_WIDTH+1:0] ext_base;
      logic signed [SAMPLE_WIDTH+1:0] ext_mag;
      logic signed [SAMPLE_WIDTH+1:0] sum;
      ext_base = {{2{base[SAMPLE_WIDTH-1]}}, base};
      ext_mag  = $signed({2'b00, mag});
      sum      = neg ? ext_base - ext_mag : ext_base + ext_mag;
      return sum[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

### design/arc_div.sv
// ----------------------------------------------------------------------------
// arc_div: rounding divider
// Unsigned restoring division of (numerator + divisor/2) by divisor, two
// quotient bits per cycle. Flags overflow when the quotient does not fit.
// ----------------------------------------------------------------------------
module arc_div
   import arc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PROD_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0]  divisor,
   output div_status_type        status,
   output logic [QUO_WIDTH-1:0]  quotient
);

   localparam int STEPS     = QUO_WIDTH / 2;
   localparam int CNT_WIDTH = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [REM_WIDTH-1:0] rem_ff, rem_in;
   logic [QUO_WIDTH-1:0] sh_ff, sh_in;
   logic [QUO_WIDTH-1:0] quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;

   logic [NUM_WIDTH-1:0] biased;
   logic [REM_WIDTH-1:0] den_ext;
   logic [REM_WIDTH-1:0] r_step;
   logic [QUO_WIDTH-1:0] sh_step;
   logic [QUO_WIDTH-1:0] q_step;

   assign biased  = NUM_WIDTH'(numerator) + NUM_WIDTH'(divisor >> 1);
   assign den_ext = REM_WIDTH'(divisor);

   always_comb begin
      r_step  = rem_ff;
      sh_step = sh_ff;
      q_step  = quo_ff;
      for (int i = 0; i < 2; i++) begin
         r_step  = {r_step[REM_WIDTH-2:0], sh_step[QUO_WIDTH-1]};
         sh_step = {sh_step[QUO_WIDTH-2:0], 1'b0};
         if (r_step >= den_ext) begin
            r_step = r_step - den_ext;
            q_step = {q_step[QUO_WIDTH-2:0], 1'b1};
         end else begin
            q_step = {q_step[QUO_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = REM_WIDTH'(biased[NUM_WIDTH-1:QUO_WIDTH]);
         sh_in   = biased[QUO_WIDTH-1:0];
         quo_in  = '0;
         ovf_in  = REM_WIDTH'(biased[NUM_WIDTH-1:QUO_WIDTH]) >= den_ext;
      end else if (busy_ff) begin
         rem_in = r_step;
         sh_in  = sh_step;
         quo_in = q_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign status.busy     = busy_ff;
   assign status.overflow = ovf_ff;
   assign quotient        = quo_ff;

endmodule

### design/actuator_response_chain.sv
// ----------------------------------------------------------------------------
// actuator_response_chain: actuator response model
// First-order lag, clamp, low-pass blend, dead zone with rescale and
// output gain on Q3.12 samples, run by a microcoded sequencer.
//
//   channel | ports  | direction | beat
//   input   | req_*  | in        | command_value, step_time
//   result  | rsp_*  | out       | actuator_output, held
//   config  | csr_*  | in        | write enable, index, data
//
// A held beat (zero step time) re-emits the last output. Other beats run
// the datapath with up to two divider passes: the lag pass runs when
// the time constant is nonzero, the dead-zone pass when the value lies
// outside the dead zone. A pass waits while the divider is busy (two
// quotient bits per cycle). One beat is in flight at a time; the result
// sits in an output register and the next beat is taken while it waits.
// Reset clears filter state, last output, CSRs to defaults and the
// sequencer. A stalled result stalls the sequencer only at its emit step.
// ----------------------------------------------------------------------------
module actuator_response_chain
   import arc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_command_value,
   input  logic [STEP_WIDTH-1:0]          req_step_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_actuator_output,
   output logic                           rsp_held,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data
);

   // sequencer and state
   logic [PC_WIDTH-1:0]            pc_ff, pc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] filt_ff, filt_in;
   logic signed [SAMPLE_WIDTH-1:0] last_ff, last_in;

   // CSRs
   logic [TAU_WIDTH-1:0]           tau_ff, tau_in;
   logic signed [SAMPLE_WIDTH-1:0] lower_ff, lower_in;
   logic signed [SAMPLE_WIDTH-1:0] upper_ff, upper_in;
   logic [BLEND_WIDTH-1:0]         blend_ff, blend_in;
   logic [DEAD_WIDTH-1:0]          dead_ff, dead_in;
   logic signed [SAMPLE_WIDTH-1:0] gain_ff, gain_in;

   // datapath
   logic signed [SAMPLE_WIDTH-1:0] cmd_ff, cmd_in;
   logic [STEP_WIDTH-1:0]          dt_ff, dt_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] base_ff, base_in;
   logic [PROD_WIDTH-1:0]          prod_ff, prod_in;
   logic                           neg_ff, neg_in;
   logic [DEN_WIDTH-1:0]           den_ff, den_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic                           held_ff, held_in;

   localparam int GRND_WIDTH = NUM_WIDTH - FRACTION_BITS;

   uword_type                      uword;
   logic signed [SAMPLE_WIDTH:0]   diff_cs;
   logic signed [SAMPLE_WIDTH:0]   diff_xb;
   logic [MAG_WIDTH-1:0]           mag_x;
   logic [MAG_WIDTH-1:0]           mag_gain;
   logic [BLEND_WIDTH-1:0]         alpha;
   logic [MUL_A_WIDTH-1:0]         mul_a;
   logic [MAG_WIDTH-1:0]           mul_b;
   logic [PROD_WIDTH-1:0]          product;
   logic [NUM_WIDTH-1:0]           rnd_b;
   logic [NUM_WIDTH-1:0]           rnd_g;
   logic [GRND_WIDTH-1:0]          r_g;
   logic signed [SAMPLE_WIDTH-1:0] clamp_lo;
   logic                           div_start;
   div_status_type                 div_status;
   logic [QUO_WIDTH-1:0]           div_quotient;

   arc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (prod_ff),
      .divisor   (den_ff),
      .status    (div_status),
      .quotient  (div_quotient)
   );

   assign uword    = ucode_rom(pc_ff);
   assign diff_cs  = {cmd_ff[SAMPLE_WIDTH-1], cmd_ff} - {filt_ff[SAMPLE_WIDTH-1], filt_ff};
   assign diff_xb  = {x_ff[SAMPLE_WIDTH-1], x_ff} - {base_ff[SAMPLE_WIDTH-1], base_ff};
   assign mag_x    = mag_of_sample(x_ff);
   assign mag_gain = mag_of_sample(gain_ff);
   assign alpha    = (blend_ff > BLEND_ONE) ? BLEND_ONE : blend_ff;
   assign product  = mul_a * mul_b;
   assign rnd_b    = NUM_WIDTH'(prod_ff) + NUM_WIDTH'(BLEND_HALF);
   assign rnd_g    = NUM_WIDTH'(prod_ff) + NUM_WIDTH'(ONE_Q / 2);
   assign r_g      = rnd_g[NUM_WIDTH-1:FRACTION_BITS];
   assign clamp_lo = (x_ff < lower_ff) ? lower_ff : x_ff;

   assign req_ready           = (uword.op == OP_WAIT);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_actuator_output = out_ff;
   assign rsp_held            = held_ff;

   always_comb begin
      pc_in        = pc_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      filt_in      = filt_ff;
      last_in      = last_ff;
      cmd_in       = cmd_ff;
      dt_in        = dt_ff;
      x_in         = x_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      out_in       = out_ff;
      held_in      = held_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      unique case (uword.op)
         OP_WAIT: begin
            if (req_valid) begin
               cmd_in = req_command_value;
               dt_in  = req_step_time;
            end else begin
               pc_in = pc_ff;
            end
         end
         OP_JHOLD: begin
            if (dt_ff == '0) begin
               pc_in = uword.target;
            end
         end
         OP_JBYP: begin
            if (tau_ff == '0) begin
               pc_in = uword.target;
            end
         end
         OP_LAGMUL: begin
            mul_a   = MUL_A_WIDTH'(dt_ff);
            mul_b   = mag_of_diff(diff_cs);
            prod_in = product;
            neg_in  = diff_cs[SAMPLE_WIDTH];
            den_in  = DEN_WIDTH'(tau_ff) + DEN_WIDTH'(dt_ff);
         end
         OP_DIVGO: begin
            div_start = 1'b1;
         end
         OP_DIVWAIT: begin
            if (div_status.busy) begin
               pc_in = pc_ff;
            end
         end
         OP_LAGFIN: begin
            x_in    = add_signed_mag(filt_ff, neg_ff, div_quotient);
            base_in = add_signed_mag(filt_ff, neg_ff, div_quotient);
            pc_in   = uword.target;
         end
         OP_BYP: begin
            x_in    = cmd_ff;
            base_in = filt_ff;
         end
         OP_CLAMP: begin
            x_in = (clamp_lo > upper_ff) ? upper_ff : clamp_lo;
         end
         OP_BLMUL: begin
            mul_a   = MUL_A_WIDTH'(alpha);
            mul_b   = mag_of_diff(diff_xb);
            prod_in = product;
            neg_in  = diff_xb[SAMPLE_WIDTH];
         end
         OP_BLFIN: begin
            x_in    = add_signed_mag(base_ff, neg_ff, rnd_b[BLEND_SHIFT +: MAG_WIDTH]);
            filt_in = add_signed_mag(base_ff, neg_ff, rnd_b[BLEND_SHIFT +: MAG_WIDTH]);
         end
         OP_DZ: begin
            if (mag_x <= MAG_WIDTH'(dead_ff)) begin
               x_in  = '0;
               pc_in = uword.target;
            end else begin
               neg_in  = x_ff[SAMPLE_WIDTH-1];
               prod_in = PROD_WIDTH'(mag_x - MAG_WIDTH'(dead_ff)) << FRACTION_BITS;
               den_in  = DEN_WIDTH'(ONE_Q) - DEN_WIDTH'(dead_ff);
            end
         end
         OP_DZFIN: begin
            if (div_status.overflow) begin
               x_in = neg_ff ? SAMPLE_MIN : SAMPLE_MAX;
            end else if (!neg_ff) begin
               x_in = div_quotient[QUO_WIDTH-1] ? SAMPLE_MAX : div_quotient;
            end else if (div_quotient[QUO_WIDTH-1] && (div_quotient[QUO_WIDTH-2:0] != '0)) begin
               x_in = SAMPLE_MIN;
            end else begin
               x_in = -div_quotient;
            end
         end
         OP_GMUL: begin
            mul_a   = MUL_A_WIDTH'(mag_x);
            mul_b   = mag_gain;
            prod_in = product;
            neg_in  = x_ff[SAMPLE_WIDTH-1] ^ gain_ff[SAMPLE_WIDTH-1];
         end
         OP_GFIN: begin
            if (!neg_ff) begin
               last_in = (r_g > GRND_WIDTH'(HALF_RANGE - 1)) ? SAMPLE_MAX
                                                             : r_g[SAMPLE_WIDTH-1:0];
            end else begin
               last_in = (r_g > GRND_WIDTH'(HALF_RANGE)) ? SAMPLE_MIN
                                                         : -r_g[SAMPLE_WIDTH-1:0];
            end
         end
         OP_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_in       = last_ff;
               held_in      = uword.held;
               pc_in        = uword.target;
            end else begin
               pc_in = pc_ff;
            end
         end
         default: begin
            pc_in = PC_FETCH;
         end
      endcase
   end

   always_comb begin
      tau_in   = tau_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      blend_in = blend_ff;
      dead_in  = dead_ff;
      gain_in  = gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LAG_TIME_CONSTANT: tau_in   = csr_write_data[TAU_WIDTH-1:0];
            CSR_LOWER_LIMIT:       lower_in = csr_write_data[SAMPLE_WIDTH-1:0];
            CSR_UPPER_LIMIT:       upper_in = csr_write_data[SAMPLE_WIDTH-1:0];
            CSR_BLEND_FACTOR:      blend_in = csr_write_data[BLEND_WIDTH-1:0];
            CSR_DEAD_BAND:         dead_in  = csr_write_data[DEAD_WIDTH-1:0];
            CSR_OUTPUT_GAIN:       gain_in  = csr_write_data[SAMPLE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         last_ff      <= '0;
         tau_ff       <= '0;
         lower_ff     <= LOWER_RESET;
         upper_ff     <= UPPER_RESET;
         blend_ff     <= BLEND_ONE;
         dead_ff      <= '0;
         gain_ff      <= GAIN_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         last_ff      <= last_in;
         tau_ff       <= tau_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         blend_ff     <= blend_in;
         dead_ff      <= dead_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dt_ff   <= dt_in;
      x_ff    <= x_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      out_ff  <= out_in;
      held_ff <= held_in;
   end

endmodule

### tb/actuator_response_chain_test.sv
// ----------------------------------------------------------------------------
// actuator_response_chain_test: self-checking bench for the actuator chain
// Drives command beats through lag, clamp, blend, dead zone and gain under
// a range of register settings. A built-in predictor tracks filter state and
// the held output. Every result beat is checked in order against it, with
// random idling on both sides of the handshake.
// ----------------------------------------------------------------------------
module actuator_response_chain_test
   import arc_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] actuator_output;
      logic                           held;
   } actuator_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_command_value = '0;
   logic [STEP_WIDTH-1:0]          req_step_time = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_actuator_output;
   logic                           rsp_held;
   logic                           csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_write_data = '0;

   // predictor copy of registers and state
   logic [TAU_WIDTH-1:0]           lag_tau = '0;
   logic signed [SAMPLE_WIDTH-1:0] lower_lim = LOWER_RESET;
   logic signed [SAMPLE_WIDTH-1:0] upper_lim = UPPER_RESET;
   logic [BLEND_WIDTH-1:0]         blend_weight = BLEND_ONE;
   logic [DEAD_WIDTH-1:0]          dead_band = '0;
   logic signed [SAMPLE_WIDTH-1:0] gain = GAIN_RESET;
   logic signed [SAMPLE_WIDTH-1:0] filter_state = '0;
   logic signed [SAMPLE_WIDTH-1:0] last_output = '0;

   actuator_result_type awaited_outputs[$];
   actuator_result_type oldest_output;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int beats_sent    = 0;
   int held_beats    = 0;
   int setting_count = 0;

   actuator_response_chain i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command_value   (req_command_value),
      .req_step_time       (req_step_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_actuator_output (rsp_actuator_output),
      .rsp_held            (rsp_held),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---- predictor ----

   function automatic longint round_div(input longint num, input longint den);
      if (num < 0)
         return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   function automatic longint clip_sample(input longint v);
      if (v > longint'(SAMPLE_MAX))
         return longint'(SAMPLE_MAX);
      if (v < longint'(SAMPLE_MIN))
         return longint'(SAMPLE_MIN);
      return v;
   endfunction

   function automatic void predict_response(input logic signed [SAMPLE_WIDTH-1:0] command,
                                            input logic [STEP_WIDTH-1:0] step);
      actuator_result_type res;
      longint cmd, dt, tau, state, lo, hi, alpha, dz;
      longint lagged, base, clamped, blended, y, g;
      cmd   = command;
      dt    = step;
      tau   = lag_tau;
      state = filter_state;
      lo    = lower_lim;
      hi    = upper_lim;
      alpha = (blend_weight > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(blend_weight);
      dz    = (dead_band >= ONE_Q) ? ONE_Q - 1 : dead_band;
      if (dt == 0) begin
         res.actuator_output = last_output;
         res.held            = 1'b1;
         held_beats++;
      end else begin
         if (tau != 0) begin
            lagged = state + round_div((cmd - state) * dt, tau + dt);
            base   = lagged;
         end else begin
            lagged = cmd;
            base   = state;
         end
         clamped = (lagged < lo) ? lo : lagged;
         if (clamped > hi)
            clamped = hi;
         blended = base + round_div(alpha * (clamped - base), 1 << BLEND_SHIFT);
         if (blended <= dz && blended >= -dz)
            y = 0;
         else if (blended > 0)
            y = clip_sample(round_div((blended - dz) * ONE_Q, ONE_Q - dz));
         else
            y = clip_sample(round_div((blended + dz) * ONE_Q, ONE_Q - dz));
         g = clip_sample(round_div(y * longint'(gain), ONE_Q));
         filter_state        = SAMPLE_WIDTH'(blended);
         last_output         = SAMPLE_WIDTH'(g);
         res.actuator_output = SAMPLE_WIDTH'(g);
         res.held            = 1'b0;
      end
      awaited_outputs.push_back(res);
   endfunction

   // ---- result checking ----

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      if (error_count < REPORT_LIMIT)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outputs.size() == 0) begin
            note_mismatch("unexpected beat", 0, rsp_actuator_output);
         end else begin
            oldest_output = awaited_outputs.pop_front();
            if (rsp_actuator_output !== oldest_output.actuator_output)
               note_mismatch("actuator_output", oldest_output.actuator_output,
                             rsp_actuator_output);
            if (rsp_held !== oldest_output.held)
               note_mismatch("held", oldest_output.held, rsp_held);
         end
      end
   end

   // ---- stimulus helpers ----

   task automatic send_command(input logic signed [SAMPLE_WIDTH-1:0] command,
                               input logic [STEP_WIDTH-1:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command_value <= command;
      req_step_time     <= step;
      do
         @(posedge clock);
      while (!req_ready);
      predict_response(command, step);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_outputs.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // unused upper data bits carry junk; the block must ignore them
   task automatic apply_settings(input logic [TAU_WIDTH-1:0] tau,
                                 input logic signed [SAMPLE_WIDTH-1:0] lo,
                                 input logic signed [SAMPLE_WIDTH-1:0] hi,
                                 input logic [BLEND_WIDTH-1:0] blend,
                                 input logic [DEAD_WIDTH-1:0] dz,
                                 input logic signed [SAMPLE_WIDTH-1:0] g);
      drain_results();
      repeat (4) @(posedge clock);
      write_csr(CSR_LAG_TIME_CONSTANT, tau);
      write_csr(CSR_LOWER_LIMIT, {8'($urandom), lo});
      write_csr(CSR_UPPER_LIMIT, {8'($urandom), hi});
      write_csr(CSR_BLEND_FACTOR, {7'($urandom), blend});
      write_csr(CSR_DEAD_BAND, {12'($urandom), dz});
      write_csr(CSR_OUTPUT_GAIN, {8'($urandom), g});
      csr_write_enable <= 1'b0;
      lag_tau      = tau;
      lower_lim    = lo;
      upper_lim    = hi;
      blend_weight = blend;
      dead_band    = dz;
      gain         = g;
      setting_count++;
   endtask

   task automatic randomize_settings();
      logic [TAU_WIDTH-1:0]           tau;
      logic signed [SAMPLE_WIDTH-1:0] lo, hi, g, swap;
      logic [BLEND_WIDTH-1:0]         blend;
      logic [DEAD_WIDTH-1:0]          dz;
      case ($urandom_range(3))
         0: tau = '0;
         1: tau = TAU_WIDTH'($urandom_range(1, 2000));
         2: tau = TAU_WIDTH'($urandom);
         default: tau = '1;
      endcase
      lo = SAMPLE_WIDTH'($urandom);
      hi = SAMPLE_WIDTH'($urandom);
      case ($urandom_range(3))
         0: begin
            lo = SAMPLE_MIN;
            hi = SAMPLE_MAX;
         end
         1, 2: begin
            if (lo > hi) begin
               swap = lo;
               lo   = hi;
               hi   = swap;
            end
         end
         default: ;
      endcase
      case ($urandom_range(3))
         0: blend = BLEND_ONE;
         1: blend = '0;
         2: blend = BLEND_WIDTH'($urandom_range(0, 65536));
         default: blend = BLEND_WIDTH'($urandom_range(65537, 131071));
      endcase
      case ($urandom_range(3))
         0: dz = '0;
         1: dz = DEAD_WIDTH'($urandom_range(1, 200));
         2: dz = DEAD_WIDTH'($urandom);
         default: dz = '1;
      endcase
      case ($urandom_range(4))
         0: g = GAIN_RESET;
         1: g = SAMPLE_MAX;
         2: g = SAMPLE_MIN;
         default: g = SAMPLE_WIDTH'($urandom);
      endcase
      apply_settings(tau, lo, hi, blend, dz, g);
   endtask

   // ---- tests ----

   task automatic test_reset_defaults();
      send_command(0, 0);
      send_command(32767, 1);
      send_command(-32768, 65535);
      send_command(-1, 0);
      send_command(1, 16'h8000);
   endtask

   task automatic test_dead_zone_edges();
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 100, GAIN_RESET);
      send_command(100, 1);
      send_command(-100, 1);
      send_command(101, 2);
      send_command(-101, 3);
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 4095, GAIN_RESET);
      send_command(4095, 1);
      send_command(4096, 1);
      send_command(-32768, 1);
   endtask

   task automatic test_gain_extremes();
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 0, SAMPLE_MIN);
      send_command(32767, 1);
      send_command(-32768, 1);
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 0, SAMPLE_MAX);
      send_command(-32768, 9);
   endtask

   task automatic test_crossed_limits();
      apply_settings(0, 1000, -1000, BLEND_ONE, 0, GAIN_RESET);
      send_command(0, 3);
      send_command(-20000, 4);
   endtask

   task automatic test_blend_weights();
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, 0, 0, GAIN_RESET);
      send_command(20000, 5);
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, '1, 0, GAIN_RESET);
      send_command(20000, 5);
      apply_settings(0, SAMPLE_MIN, SAMPLE_MAX, 32768, 0, GAIN_RESET);
      send_command(-20000, 5);
   endtask

   task automatic test_lag_extremes();
      apply_settings(1, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 0, GAIN_RESET);
      send_command(32767, 1);
      apply_settings('1, SAMPLE_MIN, SAMPLE_MAX, BLEND_ONE, 0, GAIN_RESET);
      send_command(-32768, 65535);
      send_command(32767, 1);
   endtask

   task automatic test_random_traffic(input int beats, input int send_idle,
                                      input int recv_idle);
      logic [STEP_WIDTH-1:0] step;
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      for (int i = 0; i < beats; i++) begin
         if (i % 60 == 0)
            randomize_settings();
         if ($urandom_range(49) == 0)
            drain_results();
         case ($urandom_range(9))
            0: step = '0;
            1, 2, 3, 4: step = STEP_WIDTH'($urandom_range(1, 64));
            default: step = STEP_WIDTH'($urandom);
         endcase
         send_command(SAMPLE_WIDTH'($urandom), step);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_dead_zone_edges();
      test_gain_extremes();
      test_crossed_limits();
      test_blend_weights();
      test_lag_extremes();
      test_random_traffic(370, 27, 78);
      test_random_traffic(370, 78, 27);
      test_random_traffic(360, 0, 0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_outputs.size() != 0)
         error_count++;
      $display("Run covered %0d command beats (%0d held) over %0d register settings,",
               beats_sent, held_beats, setting_count);
      $display("with %0d mismatches across lag, clamp, blend, dead zone and gain.",
               error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
